FILE: rtl/sat_pkg.sv
// sat_pkg: types and constants shared by the SCTP association tracker.
// No dependencies; compiled first.
package sat_pkg;

    localparam int TS_W  = 48;
    localparam int TAG_W = 32;
    localparam int OP_W  = 8;
    localparam int CNT_W = 2;
    localparam int ST_W  = 3;

    // chunk type codes
    localparam logic [OP_W-1:0] OP_DATA        = 8'd0;
    localparam logic [OP_W-1:0] OP_INIT        = 8'd1;
    localparam logic [OP_W-1:0] OP_INIT_ACK    = 8'd2;
    localparam logic [OP_W-1:0] OP_SACK        = 8'd3;
    localparam logic [OP_W-1:0] OP_HB          = 8'd4;
    localparam logic [OP_W-1:0] OP_HB_ACK      = 8'd5;
    localparam logic [OP_W-1:0] OP_ABORT       = 8'd6;
    localparam logic [OP_W-1:0] OP_SHUTDOWN    = 8'd7;
    localparam logic [OP_W-1:0] OP_SHUT_ACK    = 8'd8;
    localparam logic [OP_W-1:0] OP_COOKIE_ECHO = 8'd10;
    localparam logic [OP_W-1:0] OP_COOKIE_ACK  = 8'd11;
    localparam logic [OP_W-1:0] OP_SHUT_CMPL   = 8'd14;

    // reported association state codes
    localparam logic [ST_W-1:0] ST_NONE         = 3'd0;
    localparam logic [ST_W-1:0] ST_ESTABLISHING = 3'd1;
    localparam logic [ST_W-1:0] ST_ESTABLISHED  = 3'd2;
    localparam logic [ST_W-1:0] ST_CLOSING      = 3'd3;
    localparam logic [ST_W-1:0] ST_CLOSED       = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;
    localparam logic [CNT_W-1:0] CNT_ONE = 2'd1;

    typedef enum logic [3:0] {
        PH_NONE         = 4'b0001,
        PH_ESTABLISHING = 4'b0010,
        PH_ESTABLISHED  = 4'b0100,
        PH_CLOSING      = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic             from_responder;
        logic [TS_W-1:0]  timestamp_us;
        logic [TAG_W-1:0] initiate_tag;
    } t_in_item;

    typedef struct packed {
        t_phase            phase;
        logic [TAG_W-1:0]  init_tag;
        logic [TAG_W-1:0]  resp_tag;
        logic [CNT_W-1:0]  init_hb_cnt;
        logic [CNT_W-1:0]  resp_hb_cnt;
    } t_ctl_state;

    typedef struct packed {
        logic [ST_W-1:0]  assoc_state;
        logic             unknown_assoc;
        logic             new_assoc;
        logic             state_changed;
        logic             rtt_valid;
        logic [TS_W-1:0]  rtt_us;
        logic [TAG_W-1:0] initiator_tag_out;
        logic [TAG_W-1:0] responder_tag_out;
    } t_result;

endpackage

FILE: rtl/sat_in_if.sv
// sat_in_if: input chunk channel (valid/ready plus decoded chunk fields).
// Depends on sat_pkg for field widths.
interface sat_in_if;
    import sat_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic             from_responder;
    logic [TS_W-1:0]  timestamp_us;
    logic [TAG_W-1:0] initiate_tag;

    modport source (output valid, opcode, from_responder, timestamp_us, initiate_tag,
                    input ready);
    modport sink   (input valid, opcode, from_responder, timestamp_us, initiate_tag,
                    output ready);
endinterface

FILE: rtl/sat_out_if.sv
// sat_out_if: result channel (valid/ready plus tracker result fields).
// Depends on sat_pkg for field widths.
interface sat_out_if;
    import sat_pkg::*;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  assoc_state;
    logic             unknown_assoc;
    logic             new_assoc;
    logic             state_changed;
    logic             rtt_valid;
    logic [TS_W-1:0]  rtt_us;
    logic [TAG_W-1:0] initiator_tag_out;
    logic [TAG_W-1:0] responder_tag_out;

    modport source (output valid, assoc_state, unknown_assoc, new_assoc, state_changed,
                    rtt_valid, rtt_us, initiator_tag_out, responder_tag_out,
                    input ready);
    modport sink   (input valid, assoc_state, unknown_assoc, new_assoc, state_changed,
                    rtt_valid, rtt_us, initiator_tag_out, responder_tag_out,
                    output ready);
endinterface

FILE: rtl/sctp_association_tracker.sv
// sctp_association_tracker: passive single-association SCTP state tracker.
// Depends on sat_pkg, sat_in_if, sat_out_if and sat_update.
//
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   opcode, from_responder, timestamp_us, initiate_tag
//  o_out    out  valid/ready   assoc_state, unknown_assoc, new_assoc, state_changed,
//                              rtt_valid, rtt_us, initiator_tag_out, responder_tag_out
//
// One item per cycle sustained while the output is not stalled; each item passes
// through the input register, then the result register. The state update of an item
// and the load of its result register happen on the same edge, so the next item
// sees it. A stalled output holds the result register and then the input register;
// the input is ready whenever the input register is empty or moving on.
// Synchronous active-low reset returns to "no association" with zero tags.
module sctp_association_tracker #(
    parameter int TIME_BITS = 48
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sat_in_if.sink    i_in,
    sat_out_if.source o_out
);
    import sat_pkg::*;

    // Timestamps are 48 bits on the ports, so only min(TIME_BITS, 48) bits of
    // heartbeat time ever matter; the wraparound of the RTT follows that width.
    localparam int TW = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;

    // input register
    logic       r_in_valid;
    t_in_item   r_in;

    // association state
    t_ctl_state    r_st;
    logic [TW-1:0] r_init_hb_time;
    logic [TW-1:0] r_resp_hb_time;

    // result register
    logic       r_out_valid;
    t_result    r_res;

    // next values from the update logic
    t_ctl_state    n_st;
    logic [TW-1:0] n_init_hb_time;
    logic [TW-1:0] n_resp_hb_time;
    t_result       n_res;

    logic advance;   // input register item moves into the result register
    logic in_take;

    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_take = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_valid || advance;

    sat_update #(
        .TW (TW)
    ) u_update (
        .i_item         (r_in),
        .i_st           (r_st),
        .i_init_hb_time (r_init_hb_time),
        .i_resp_hb_time (r_resp_hb_time),
        .o_st           (n_st),
        .o_init_hb_time (n_init_hb_time),
        .o_resp_hb_time (n_resp_hb_time),
        .o_res          (n_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in.opcode         <= i_in.opcode;
            r_in.from_responder <= i_in.from_responder;
            r_in.timestamp_us   <= i_in.timestamp_us;
            r_in.initiate_tag   <= i_in.initiate_tag;
        end
    end

    // association state; heartbeat times are only read after being written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase       <= PH_NONE;
            r_st.init_tag    <= '0;
            r_st.resp_tag    <= '0;
            r_st.init_hb_cnt <= '0;
            r_st.resp_hb_cnt <= '0;
        end else if (advance) begin
            r_st <= n_st;
        end
        if (advance) begin
            r_init_hb_time <= n_init_hb_time;
            r_resp_hb_time <= n_resp_hb_time;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.assoc_state       = r_res.assoc_state;
    assign o_out.unknown_assoc     = r_res.unknown_assoc;
    assign o_out.new_assoc         = r_res.new_assoc;
    assign o_out.state_changed     = r_res.state_changed;
    assign o_out.rtt_valid         = r_res.rtt_valid;
    assign o_out.rtt_us            = r_res.rtt_us;
    assign o_out.initiator_tag_out = r_res.initiator_tag_out;
    assign o_out.responder_tag_out = r_res.responder_tag_out;

    // a closing chunk leaves no association behind
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_res.assoc_state == ST_CLOSED |=> r_st.phase == PH_NONE)
        else $error("association not deleted after close");

    // creation always lands in establishing and is never flagged unknown
    a_new_assoc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.new_assoc |->
            r_res.assoc_state == ST_ESTABLISHING && !r_res.unknown_assoc)
        else $error("new association reported with wrong state");

    // no RTT value without a measurement
    a_rtt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.rtt_valid |-> r_res.rtt_us == '0)
        else $error("rtt_us nonzero without rtt_valid");

    // a result register holding an unread item is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_res))
        else $error("pending result lost");

    // without an association every tag reads as zero
    a_none_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == PH_NONE |-> r_st.init_tag == '0 && r_st.resp_tag == '0)
        else $error("tags held with no association");

endmodule

FILE: rtl/sat_update.sv
// sat_update: next-state and result logic for one chunk.
// Depends on sat_pkg. Purely combinational.
module sat_update #(
    parameter int TW = 48
) (
    input  sat_pkg::t_in_item   i_item,
    input  sat_pkg::t_ctl_state i_st,
    input  logic [TW-1:0]       i_init_hb_time,
    input  logic [TW-1:0]       i_resp_hb_time,
    output sat_pkg::t_ctl_state o_st,
    output logic [TW-1:0]       o_init_hb_time,
    output logic [TW-1:0]       o_resp_hb_time,
    output sat_pkg::t_result    o_res
);
    import sat_pkg::*;

    logic          exists;
    logic          closed;
    logic          resp;
    logic [TW-1:0] ts;
    logic [TW-1:0] rtt;

    always_comb begin
        exists = (i_st.phase != PH_NONE);
        resp   = i_item.from_responder;
        ts     = i_item.timestamp_us[TW-1:0];
        closed = 1'b0;
        rtt    = '0;

        o_st           = i_st;
        o_init_hb_time = i_init_hb_time;
        o_resp_hb_time = i_resp_hb_time;
        o_res          = '0;

        unique case (i_item.opcode)
            OP_INIT: begin
                if (!exists) begin
                    o_st.phase       = PH_ESTABLISHING;
                    o_st.init_tag    = i_item.initiate_tag;
                    o_st.resp_tag    = '0;
                    o_st.init_hb_cnt = '0;
                    o_st.resp_hb_cnt = '0;
                    o_init_hb_time   = '0;
                    o_resp_hb_time   = '0;
                    o_res.new_assoc  = 1'b1;
                end else if (!resp) begin
                    o_st.init_tag = i_item.initiate_tag;
                end else if (i_st.phase == PH_ESTABLISHING) begin
                    o_st.resp_tag = i_item.initiate_tag;
                end
            end
            OP_DATA, OP_SACK, OP_COOKIE_ACK: begin
                o_res.unknown_assoc = !exists;
            end
            OP_INIT_ACK: begin
                o_res.unknown_assoc = !exists;
                if (resp && i_st.phase == PH_ESTABLISHING)
                    o_st.resp_tag = i_item.initiate_tag;
            end
            OP_COOKIE_ECHO: begin
                o_res.unknown_assoc = !exists;
                if (i_st.phase == PH_ESTABLISHING) begin
                    o_st.phase          = PH_ESTABLISHED;
                    o_res.state_changed = 1'b1;
                end
            end
            OP_SHUTDOWN: begin
                o_res.unknown_assoc = !exists;
                if (i_st.phase == PH_ESTABLISHED) begin
                    o_st.phase          = PH_CLOSING;
                    o_res.state_changed = 1'b1;
                end
            end
            OP_SHUT_CMPL: begin
                o_res.unknown_assoc = !exists;
                if (i_st.phase == PH_CLOSING) begin
                    closed              = 1'b1;
                    o_res.state_changed = 1'b1;
                end
            end
            OP_ABORT, OP_SHUT_ACK: begin
                o_res.unknown_assoc = !exists;
                if (exists) begin
                    closed              = 1'b1;
                    o_res.state_changed = 1'b1;
                end
            end
            OP_HB: begin
                o_res.unknown_assoc = !exists;
                if (i_st.phase == PH_ESTABLISHED) begin
                    if (resp) begin
                        if (i_st.resp_hb_cnt != CNT_MAX)
                            o_st.resp_hb_cnt = i_st.resp_hb_cnt + CNT_ONE;
                        o_resp_hb_time = ts;
                    end else begin
                        if (i_st.init_hb_cnt != CNT_MAX)
                            o_st.init_hb_cnt = i_st.init_hb_cnt + CNT_ONE;
                        o_init_hb_time = ts;
                    end
                end
            end
            OP_HB_ACK: begin
                // an ack from one side closes the other side's heartbeat
                o_res.unknown_assoc = !exists;
                if (exists) begin
                    if (resp) begin
                        if (i_st.init_hb_cnt == CNT_ONE) begin
                            o_res.rtt_valid = 1'b1;
                            rtt             = ts - i_init_hb_time;
                        end
                        o_st.init_hb_cnt = '0;
                    end else begin
                        if (i_st.resp_hb_cnt == CNT_ONE) begin
                            o_res.rtt_valid = 1'b1;
                            rtt             = ts - i_resp_hb_time;
                        end
                        o_st.resp_hb_cnt = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        o_res.rtt_us            = TS_W'(rtt);
        o_res.initiator_tag_out = o_st.init_tag;
        o_res.responder_tag_out = o_st.resp_tag;

        unique case (o_st.phase)
            PH_NONE:         o_res.assoc_state = ST_NONE;
            PH_ESTABLISHING: o_res.assoc_state = ST_ESTABLISHING;
            PH_ESTABLISHED:  o_res.assoc_state = ST_ESTABLISHED;
            PH_CLOSING:      o_res.assoc_state = ST_CLOSING;
            default:         o_res.assoc_state = ST_NONE;
        endcase

        // deletion: report closed with the old tags, then drop everything
        if (closed) begin
            o_res.assoc_state = ST_CLOSED;
            o_st.phase        = PH_NONE;
            o_st.init_tag     = '0;
            o_st.resp_tag     = '0;
            o_st.init_hb_cnt  = '0;
            o_st.resp_hb_cnt  = '0;
            o_init_hb_time    = '0;
            o_resp_hb_time    = '0;
        end
    end

endmodule
